@@ hw/rtl/takf_pkg.sv @@
// Package: shared constants and types for the tilt-angle Kalman fusion unit.
`default_nettype none
package takf_pkg;
   localparam int NUM_AXES = 3;
   localparam int AXIS_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 23;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_Q_BIAS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_R_MEAS  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DT      = 2'd3;
   localparam logic signed [31:0] Q_ONE = 32'sd65536;

   typedef struct packed {
      logic [AXIS_W-1:0] axis;
      logic signed [31:0] measured_angle;
      logic signed [31:0] gyro_rate;
   } req_type;

   typedef struct packed {
      logic [AXIS_W-1:0] axis_echo;
      logic signed [31:0] filtered_angle;
      logic signed [31:0] corrected_rate;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) return 32'sh7fffffff;
      else if (v < -66'sd2147483648) return 32'sh80000000;
      else return v[31:0];
   endfunction
endpackage
`default_nettype wire

@@ hw/rtl/takf_if.sv @@
// Interfaces: valid/ready channels for requests and responses.
`default_nettype none
interface takf_req_if import takf_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface takf_rsp_if import takf_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tilt_angle_kalman_fusion_unit.sv @@
// Top level: sequenced two-state tilt Kalman filter, one state set per axis.
// One request at a time: ten multiply steps through one shared registered
// multiplier plus two 48-iteration divides in one iterative divider. The
// response is registered, and a new request is accepted only once the unit is
// back in idle and the last response has been taken. The divider takes most
// of the time per request, and a stalled response holds off the next request.
// Requests with an axis of NUM_AXES or more are dropped with no response.
// Per-axis state lives in flip-flops (six words per axis) and resets to
// angle 0, bias 0, P = I.
`default_nettype none
module tilt_angle_kalman_fusion_unit import takf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   takf_req_if.sink   req,
   takf_rsp_if.source rsp,
   input  wire logic csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_idx,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);
   localparam logic [4:0] S_IDLE=5'd0, S_M1=5'd1, S_M2=5'd2, S_M3=5'd3, S_M4=5'd4,
      S_M5=5'd5, S_P1=5'd6, S_D0=5'd7, S_W0=5'd8, S_D1=5'd9, S_W1=5'd10,
      S_U1=5'd11, S_U2=5'd12, S_U3=5'd13, S_U4=5'd14, S_U5=5'd15, S_U6=5'd16,
      S_OUT=5'd17, S_X=5'd18;

   logic [15:0] qa_ff, qb_ff, dt_ff;
   logic [22:0] r_ff;
   logic signed [31:0] ang_ff[NUM_AXES], bias_ff[NUM_AXES], paa_ff[NUM_AXES],
      pab_ff[NUM_AXES], pba_ff[NUM_AXES], pbb_ff[NUM_AXES];

   logic [4:0] st_ff;
   logic [AXIS_W-1:0] ax_ff;
   logic signed [31:0] meas_ff, gyro_ff;
   // working copies
   logic signed [31:0] a_ff, b_ff, paa_w, pab_w, pba_w, pbb_w, d0_ff, k0_ff, err_ff;
   logic signed [31:0] ma, mb, mq, dq;
   logic ds;
   logic signed [31:0] dp;
   logic dbusy;
   logic rv_ff;
   rsp_type rd_ff;

   takf_mul u_mul (.clock(clock), .a(ma), .b(mb), .q(mq));
   takf_div u_div (.clock(clock), .reset(reset), .start(ds), .p(dp),
      .e(34'(r_ff) + 34'(paa_w)), .busy(dbusy), .q(dq));

   assign req.ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.data = rd_ff;

   // multiplier operands per step; the product is ready in the next cycle
   always_comb begin
      ma = '0; mb = '0;
      unique case (st_ff)
         S_M1: begin ma = sat32(66'(gyro_ff) - 66'(b_ff)); mb = $signed({16'd0, dt_ff}); end
         S_M2: begin ma = pbb_w; mb = $signed({16'd0, dt_ff}); end
         S_M3: begin ma = $signed({16'd0, qb_ff}); mb = $signed({16'd0, dt_ff}); end
         S_M4: begin ma = d0_ff; mb = $signed({16'd0, dt_ff}); end
         S_U1: begin ma = k0_ff; mb = paa_w; end
         S_U2: begin ma = dq; mb = pab_w; end
         S_U3: begin ma = dq; mb = paa_w; end
         S_U4: begin ma = k0_ff; mb = pab_w; end
         S_U5: begin ma = k0_ff; mb = err_ff; end
         S_U6: begin ma = dq; mb = err_ff; end
         default: ;
      endcase
   end
   assign ds = (st_ff == S_D0) || (st_ff == S_D1);
   assign dp = (st_ff == S_D0) ? paa_w : pba_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; rv_ff <= 1'b0;
         qa_ff <= 16'd66; qb_ff <= 16'd197; r_ff <= 23'd32768; dt_ff <= 16'd328;
         for (int i = 0; i < NUM_AXES; i++) begin
            ang_ff[i] <= '0; bias_ff[i] <= '0; paa_ff[i] <= Q_ONE;
            pab_ff[i] <= '0; pba_ff[i] <= '0; pbb_ff[i] <= Q_ONE;
         end
      end else begin
         if (csr_we) begin
            unique case (csr_idx)
               CSR_Q_ANGLE: qa_ff <= csr_wdata[15:0];
               CSR_Q_BIAS:  qb_ff <= csr_wdata[15:0];
               CSR_R_MEAS:  r_ff <= csr_wdata;
               CSR_DT:      dt_ff <= csr_wdata[15:0];
            endcase
         end
         if (rv_ff && rsp.ready) rv_ff <= 1'b0;
         unique case (st_ff)
            S_IDLE: if (req.valid && req.ready &&
                        32'(req.data.axis) < NUM_AXES) begin
               ax_ff <= req.data.axis;
               meas_ff <= req.data.measured_angle;
               gyro_ff <= req.data.gyro_rate;
               a_ff <= ang_ff[req.data.axis]; b_ff <= bias_ff[req.data.axis];
               paa_w <= paa_ff[req.data.axis]; pab_w <= pab_ff[req.data.axis];
               pba_w <= pba_ff[req.data.axis]; pbb_w <= pbb_ff[req.data.axis];
               d0_ff <= sat32(66'($signed({1'b0, qa_ff})) -
                  66'(pab_ff[req.data.axis]) - 66'(pba_ff[req.data.axis]));
               st_ff <= S_M1;
            end
            S_M1: st_ff <= S_M2;
            S_M2: begin a_ff <= sat32(66'(a_ff) + 66'(mq)); st_ff <= S_M3; end
            S_M3: begin
               pab_w <= sat32(66'(pab_w) - 66'(mq));
               pba_w <= sat32(66'(pba_w) - 66'(mq));
               st_ff <= S_M4;
            end
            S_M4: begin pbb_w <= sat32(66'(pbb_w) + 66'(mq)); st_ff <= S_M5; end
            S_M5: begin
               paa_w <= sat32(66'(paa_w) + 66'(mq));
               st_ff <= S_P1;
            end
            S_P1: begin err_ff <= sat32(66'(meas_ff) - 66'(a_ff)); st_ff <= S_D0; end
            S_D0: st_ff <= S_W0;
            S_W0: if (!dbusy) st_ff <= S_D1;
            S_D1: begin k0_ff <= dq; st_ff <= S_W1; end
            S_W1: if (!dbusy) st_ff <= S_U1;
            // dq now holds K1 until next start
            S_U1: st_ff <= S_U2;
            S_U2: begin d0_ff <= mq; st_ff <= S_U3; end        // K0*Paa
            // K1*Pab, taken while Pab still holds its predicted value
            S_U3: begin pbb_w <= sat32(66'(pbb_w) - 66'(mq)); st_ff <= S_U4; end
            S_U4: begin pba_w <= sat32(66'(pba_w) - 66'(mq)); st_ff <= S_U5; end
            S_U5: begin pab_w <= sat32(66'(pab_w) - 66'(mq)); st_ff <= S_U6; end
            S_U6: begin a_ff <= sat32(66'(a_ff) + 66'(mq)); st_ff <= S_X; end
            S_X: begin
               b_ff <= sat32(66'(b_ff) + 66'(mq));
               paa_w <= sat32(66'(paa_w) - 66'(d0_ff));
               st_ff <= S_OUT;
            end
            S_OUT: begin
               ang_ff[ax_ff] <= a_ff; bias_ff[ax_ff] <= b_ff; paa_ff[ax_ff] <= paa_w;
               pab_ff[ax_ff] <= pab_w; pba_ff[ax_ff] <= pba_w; pbb_ff[ax_ff] <= pbb_w;
               rd_ff.axis_echo <= ax_ff;
               rd_ff.filtered_angle <= a_ff;
               rd_ff.corrected_rate <= sat32(66'(gyro_ff) - 66'(b_ff));
               rv_ff <= 1'b1;
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

@@ hw/rtl/takf_mul.sv @@
// Shared Q16.16 multiplier: one registered product, round half up, saturate.
`default_nettype none
module takf_mul import takf_pkg::*; (
   input  wire logic clock,
   input  wire logic signed [31:0] a,
   input  wire logic signed [31:0] b,
   output logic signed [31:0] q
);
   logic signed [63:0] p_ff;
   logic signed [63:0] p_in;
   logic signed [65:0] r;
   assign p_in = a * b;
   always_ff @(posedge clock) begin
      p_ff <= p_in;
   end
   // arithmetic shift floors
   assign r = (66'(p_ff) + 66'sd32768) >>> 16;
   assign q = sat32(r);
endmodule
`default_nettype wire

@@ hw/rtl/takf_div.sv @@
// Iterative signed divider for the gain: sat32((p<<16)/e), truncating, zero on e==0.
`default_nettype none
module takf_div import takf_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire logic signed [31:0] p,
   input  wire logic signed [33:0] e,
   output logic busy,
   output logic signed [31:0] q
);
   logic [47:0] num_ff, num_in;
   logic [33:0] den_ff, den_in;
   logic [33:0] rem_ff, rem_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        neg_ff, neg_in, zero_ff, zero_in, busy_ff, busy_in;
   logic signed [31:0] q_ff, q_in;
   logic [34:0] sh;
   logic signed [49:0] sq;
   logic signed [47:0] pn;

   assign pn = {p, 16'd0};
   assign sh = {rem_ff, num_ff[47]};

   always_comb begin
      num_in = num_ff; den_in = den_ff; rem_in = rem_ff; cnt_in = cnt_ff;
      neg_in = neg_ff; zero_in = zero_ff; busy_in = busy_ff; q_in = q_ff;
      sq = '0;
      if (start) begin
         num_in = pn[47] ? 48'(-pn) : 48'(pn);
         den_in = e[33] ? 34'(-e) : 34'(e);
         neg_in = pn[47] ^ e[33];
         zero_in = (e == 34'sd0);
         rem_in = '0;
         cnt_in = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // remainder stays below the divisor, so it fits in 34 bits
         if (sh >= {1'b0, den_ff}) begin
            rem_in = 34'(sh - {1'b0, den_ff});
            num_in = {num_ff[46:0], 1'b1};
         end else begin
            rem_in = sh[33:0];
            num_in = {num_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            sq = neg_ff ? -50'(num_in) : 50'(num_in);
            q_in = zero_ff ? 32'sd0 : sat32(66'(sq));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      num_ff <= num_in; den_ff <= den_in; rem_ff <= rem_in;
      neg_ff <= neg_in; zero_ff <= zero_in; q_ff <= q_in;
   end
   assign busy = busy_ff;
   assign q = q_ff;
endmodule
`default_nettype wire
